@@ design/imad_pkg.sv @@
// Shared types, constants and helpers for the multichannel IMA ADPCM decoder.
// No dependencies; every other design file takes names from here by scope.
`timescale 1ns / 1ps

package imad_pkg;

    typedef enum logic [1:0] {
        REQ_DECODE = 2'd0,
        REQ_SKIP   = 2'd1,
        REQ_LOAD   = 2'd2
    } req_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_ORDER = 1'b1;

    localparam int                 STEP_COUNT     = 89;
    localparam logic [6:0]         STEP_MAX_INDEX = 7'd88;
    localparam logic signed [17:0] PRED_MAX       = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN_IMA   = -18'sd32768;
    localparam logic signed [17:0] PRED_MIN_NDS   = -18'sd32767;

    localparam logic [15:0] STEP_TABLE [STEP_COUNT] = '{
        16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,    16'd13,
        16'd14,    16'd16,    16'd17,    16'd19,    16'd21,    16'd23,    16'd25,
        16'd28,    16'd31,    16'd34,    16'd37,    16'd41,    16'd45,    16'd50,
        16'd55,    16'd60,    16'd66,    16'd73,    16'd80,    16'd88,    16'd97,
        16'd107,   16'd118,   16'd130,   16'd143,   16'd157,   16'd173,   16'd190,
        16'd209,   16'd230,   16'd253,   16'd279,   16'd307,   16'd337,   16'd371,
        16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,   16'd724,
        16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,  16'd1411,
        16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,  16'd2749,
        16'd3024,  16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,  16'd5358,
        16'd5894,  16'd6484,  16'd7132,  16'd7845,  16'd8630,  16'd9493,  16'd10442,
        16'd11487, 16'd12635, 16'd13899, 16'd15289, 16'd16818, 16'd18500, 16'd20350,
        16'd22385, 16'd24623, 16'd27086, 16'd29794, 16'd32767
    };

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         channel;
        logic [7:0]         data_byte;
        logic signed [15:0] init_predictor;
        logic signed [15:0] init_step_index;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         sample_channel;
        logic               last;
    } out_item_t;

    // what one cell hands to the next
    typedef struct packed {
        req_t               op;
        logic [2:0]         ch;
        logic [3:0]         code;
        logic [3:0]         code_next;
        logic signed [15:0] pred;
        logic [6:0]         idx;
        logic signed [15:0] prev;
    } cell_data_t;

    function automatic logic [15:0] step_size(input logic [6:0] idx);
        if (idx > STEP_MAX_INDEX) begin
            return STEP_TABLE[STEP_MAX_INDEX];
        end
        return STEP_TABLE[idx];
    endfunction

    function automatic logic signed [15:0] clamp_pred(input logic signed [17:0] p,
                                                      input logic nds);
        logic signed [17:0] lo;
        lo = nds ? PRED_MIN_NDS : PRED_MIN_IMA;
        if (p > PRED_MAX) begin
            return PRED_MAX[15:0];
        end
        if (p < lo) begin
            return lo[15:0];
        end
        return p[15:0];
    endfunction

endpackage

@@ design/imad_nibble_cell.sv @@
// One decoder cell: applies one 4-bit code to a predictor / step index pair
// and registers the result for the next cell. Depends on imad_pkg.
`timescale 1ns / 1ps

module imad_nibble_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 clamp_mode,
    input  logic                 in_valid,
    input  imad_pkg::cell_data_t in_data,
    output logic                 out_valid,
    output imad_pkg::cell_data_t out_data,
    output imad_pkg::cell_data_t out_next
);

    logic                 valid_reg;
    imad_pkg::cell_data_t data_reg;

    logic [15:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] pred_wide;
    logic signed [17:0] pred_sum;
    logic [7:0]         idx_adj;
    logic [7:0]         idx_sum;
    logic [6:0]         idx_new;

    always_comb begin
        step = imad_pkg::step_size(in_data.idx);
        diff = 17'(step >> 3);
        if (in_data.code[0]) begin
            diff = diff + 17'(step >> 2);
        end
        if (in_data.code[1]) begin
            diff = diff + 17'(step >> 1);
        end
        if (in_data.code[2]) begin
            diff = diff + 17'(step);
        end
        pred_wide = 18'(in_data.pred);
        if (in_data.code[3]) begin
            pred_sum = pred_wide - $signed({1'b0, diff});
        end else begin
            pred_sum = pred_wide + $signed({1'b0, diff});
        end

        // large codes move the index up by 2, 4, 6 or 8; small ones drop it by one
        if (in_data.code[2]) begin
            idx_adj = {5'd0, in_data.code[1:0], 1'b0} + 8'd2;
        end else begin
            idx_adj = 8'hFF;
        end
        idx_sum = {1'b0, in_data.idx} + idx_adj;
        if (idx_sum[7]) begin
            idx_new = 7'd0;
        end else if (idx_sum[6:0] > imad_pkg::STEP_MAX_INDEX) begin
            idx_new = imad_pkg::STEP_MAX_INDEX;
        end else begin
            idx_new = idx_sum[6:0];
        end

        out_next           = in_data;
        out_next.code      = in_data.code_next;
        out_next.code_next = in_data.code;
        out_next.prev      = in_data.pred;
        // a load item passes through with its state untouched
        if (in_data.op != imad_pkg::REQ_LOAD) begin
            out_next.pred = imad_pkg::clamp_pred(pred_sum, clamp_mode);
            out_next.idx  = idx_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/ima_adpcm_multichannel_decoder_unit.sv @@
// Top level of the multichannel IMA ADPCM decoder: input register, two chained
// nibble cells, per-channel state and the result port. Depends on imad_pkg, imad_nibble_cell.
`timescale 1ns / 1ps

// Each accepted item passes an input register and two decoder cells, one per
// nibble; the second cell's register is the result register. A decode item
// gives its two samples from the result register, first then last, and holds
// that register until its last sample is taken, at one sample per cycle while
// m_ready is high. Skip and load items give no result and flow at one item per
// cycle unless a decode item holds the second cell or a channel hazard holds
// them. An item for the same channel as the item in the first cell waits until
// that channel's state has been written back. Reserved request types and
// channels at or above CHANNELS are taken and dropped. Configuration writes are
// taken in any cycle.

module ima_adpcm_multichannel_decoder_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [imad_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [imad_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  imad_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output imad_pkg::out_item_t                m_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic clamp_mode_reg;
    logic nibble_order_reg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    imad_pkg::cell_data_t in_data_reg;
    imad_pkg::cell_data_t in_data_next;

    logic signed [15:0] pred_reg [CHANNELS];
    logic [6:0]         idx_reg  [CHANNELS];

    logic                 phase_reg;
    logic                 phase_next;

    logic                 keep;
    logic                 hazard;
    logic                 adv0;
    logic                 adv1;
    logic                 in_adv;
    logic                 c1_busy;
    imad_pkg::cell_data_t c0_in;
    logic                 c0_valid;
    imad_pkg::cell_data_t c0_data;
    imad_pkg::cell_data_t c0_next;
    logic                 c1_valid;
    imad_pkg::cell_data_t c1_data;
    imad_pkg::cell_data_t c1_next;
    logic [CH_W-1:0]      rd_ch;
    logic [CH_W-1:0]      wr_ch;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_mode_reg   <= 1'b0;
            nibble_order_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                imad_pkg::REG_CLAMP_MODE:   clamp_mode_reg   <= cfg_wr_data[0];
                imad_pkg::REG_NIBBLE_ORDER: nibble_order_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    always_comb begin
        c1_busy = c1_valid && (c1_data.op == imad_pkg::REQ_DECODE)
                  && !(phase_reg && m_ready);
        adv1    = !c1_busy;
        adv0    = !c0_valid || adv1;
        // hold an item whose channel is still in flight in the first cell
        hazard  = c0_valid && (c0_data.ch == in_data_reg.ch);
        in_adv  = in_valid_reg && adv0 && !hazard;
        s_ready = !in_valid_reg || in_adv;
    end

    // build the cell item at accept
    always_comb begin
        keep = ((s_data.req_type == imad_pkg::REQ_DECODE)
                || (s_data.req_type == imad_pkg::REQ_SKIP)
                || (s_data.req_type == imad_pkg::REQ_LOAD))
               && ({29'd0, s_data.channel} < 32'(CHANNELS));

        in_data_next.op        = imad_pkg::req_t'(s_data.req_type);
        in_data_next.ch        = s_data.channel;
        in_data_next.code      = nibble_order_reg ? s_data.data_byte[7:4]
                                                  : s_data.data_byte[3:0];
        in_data_next.code_next = nibble_order_reg ? s_data.data_byte[3:0]
                                                  : s_data.data_byte[7:4];
        in_data_next.pred      = imad_pkg::clamp_pred(18'(s_data.init_predictor),
                                                      clamp_mode_reg);
        if (s_data.init_step_index < 16'sd0) begin
            in_data_next.idx = 7'd0;
        end else if (s_data.init_step_index > 16'(imad_pkg::STEP_MAX_INDEX)) begin
            in_data_next.idx = imad_pkg::STEP_MAX_INDEX;
        end else begin
            in_data_next.idx = s_data.init_step_index[6:0];
        end
        in_data_next.prev      = 16'sd0;

        priority if (s_valid && s_ready) begin
            in_valid_next = keep;
        end else if (in_adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= in_data_next;
        end
    end

    // first cell reads the channel state unless the item loads it
    always_comb begin
        rd_ch = CH_W'(in_data_reg.ch);
        c0_in = in_data_reg;
        if (in_data_reg.op != imad_pkg::REQ_LOAD) begin
            c0_in.pred = pred_reg[rd_ch];
            c0_in.idx  = idx_reg[rd_ch];
        end
    end

    imad_nibble_cell u_cell0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv0),
        .clamp_mode (clamp_mode_reg),
        .in_valid   (in_adv),
        .in_data    (c0_in),
        .out_valid  (c0_valid),
        .out_data   (c0_data),
        .out_next   (c0_next)
    );

    imad_nibble_cell u_cell1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv1),
        .clamp_mode (clamp_mode_reg),
        .in_valid   (c0_valid),
        .in_data    (c0_data),
        .out_valid  (c1_valid),
        .out_data   (c1_data),
        .out_next   (c1_next)
    );

    // write back the channel state as the second cell takes the item
    assign wr_ch = CH_W'(c0_data.ch);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pred_reg[i] <= 16'sd0;
                idx_reg[i]  <= 7'd0;
            end
        end else if (adv1 && c0_valid) begin
            pred_reg[wr_ch] <= c1_next.pred;
            idx_reg[wr_ch]  <= c1_next.idx;
        end
    end

    // result port: first sample, then the last one
    always_comb begin
        m_valid               = c1_valid && (c1_data.op == imad_pkg::REQ_DECODE);
        m_data.sample         = phase_reg ? c1_data.pred : c1_data.prev;
        m_data.sample_channel = c1_data.ch;
        m_data.last           = phase_reg;
        phase_next            = (m_valid && m_ready) ? !phase_reg : phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

@@ design/imad_checker.sv @@
// Port-level checks for the multichannel IMA ADPCM decoder, bound to the top.
// Depends on imad_pkg and ima_adpcm_multichannel_decoder_unit.
`timescale 1ns / 1ps

module imad_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input imad_pkg::out_item_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && m_data.last
            && (m_data.sample_channel == $past(m_data.sample_channel)))
        else $error("first sample not followed by last sample of same channel");

    a_new_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> !(m_valid && m_data.last))
        else $error("last sample not followed by a first sample");

endmodule

bind ima_adpcm_multichannel_decoder_unit imad_checker u_imad_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
